FILE: sv/ntis_pkg.sv
// ----------------------------------------------------------------------------
// ntis_pkg
// Shared types and constants of the nearest target in sector unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ntis_pkg;

    // configuration register indexes
    typedef logic [7:0] cfg_index_t;
    localparam cfg_index_t CFG_REACH = 8'd0;
    localparam cfg_index_t CFG_COS   = 8'd1;

    localparam logic        [22:0] REACH_RESET = 23'd200;
    localparam logic signed [15:0] COS_RESET   = 16'sd23170;

    typedef struct packed {
        logic        [22:0] reach;
        logic signed [15:0] cos_half_arc;
    } cfg_t;

    // classified candidate: offset and forward split into sign and magnitude
    typedef struct packed {
        logic [23:0] adx;
        logic [23:0] ady;
        logic        sdx;
        logic        sdy;
        logic [15:0] afx;
        logic [15:0] afy;
        logic        sfx;
        logic        sfy;
        logic        alive;
        logic        last;
        logic [7:0]  idx;
    } cand_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

FILE: sv/ntis_front.sv
// ----------------------------------------------------------------------------
// ntis_front
// Accepts candidate requests, numbers them and reduces them to offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module ntis_front #(
    parameter int MAX_CANDIDATES = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic               q_full,
    input  wire logic signed [23:0] player_x,
    input  wire logic signed [23:0] player_y,
    input  wire logic signed [15:0] forward_x,
    input  wire logic signed [15:0] forward_y,
    input  wire logic signed [23:0] cand_x,
    input  wire logic signed [23:0] cand_y,
    input  wire logic signed [10:0] remaining_health,
    input  wire logic               last_candidate,
    output logic                    q_push,
    output ntis_pkg::cand_t         q_entry
);

    localparam int IDX_W = $clog2(MAX_CANDIDATES + 1);

    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic             in_range;
    logic             health_ok;
    logic [24:0]      dx;
    logic [24:0]      dy;
    logic [24:0]      dx_mag;
    logic [24:0]      dy_mag;

    assign q_push    = push && !q_full;
    assign in_range  = cnt_reg < IDX_W'(MAX_CANDIDATES);
    assign health_ok = !remaining_health[10] && (remaining_health != 11'sd0);

    assign dx     = {cand_x[23], cand_x} - {player_x[23], player_x};
    assign dy     = {cand_y[23], cand_y} - {player_y[23], player_y};
    assign dx_mag = dx[24] ? (~dx + 25'd1) : dx;
    assign dy_mag = dy[24] ? (~dy + 25'd1) : dy;

    always_comb
    begin
        q_entry.adx   = dx_mag[23:0];
        q_entry.ady   = dy_mag[23:0];
        q_entry.sdx   = dx[24];
        q_entry.sdy   = dy[24];
        q_entry.afx   = forward_x[15] ? (~forward_x + 16'd1) : forward_x;
        q_entry.afy   = forward_y[15] ? (~forward_y + 16'd1) : forward_y;
        q_entry.sfx   = forward_x[15];
        q_entry.sfy   = forward_y[15];
        q_entry.alive = health_ok && in_range;
        q_entry.last  = last_candidate;
        q_entry.idx   = 8'(cnt_reg);
    end

    // saturate at the list limit, restart after the last candidate
    always_comb
    begin
        cnt_next = cnt_reg;
        if (q_push)
        begin
            if (last_candidate)
                cnt_next = '0;
            else if (in_range)
                cnt_next = cnt_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

`default_nettype wire

FILE: sv/ntis_fifo.sv
// ----------------------------------------------------------------------------
// ntis_fifo
// Short queue of classified candidates between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ntis_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire ntis_pkg::cand_t wr_data,
    input  wire logic            rd_en,
    output ntis_pkg::cand_t      rd_data,
    output logic                 full,
    output logic                 empty
);

    ntis_pkg::cand_t                  mem_reg [ntis_pkg::QUEUE_DEPTH];
    logic [ntis_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [ntis_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [ntis_pkg::QUEUE_PTR_W:0]   count_reg;
    logic                             do_wr;
    logic                             do_rd;

    assign full    = count_reg == (ntis_pkg::QUEUE_PTR_W + 1)'(ntis_pkg::QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: sv/ntis_back.sv
// ----------------------------------------------------------------------------
// ntis_back
// Range and cone tests on one shared multiplier, best tracking, result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module ntis_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ntis_pkg::cfg_t  cfg,
    input  wire logic            q_empty,
    input  wire ntis_pkg::cand_t q_head,
    output logic                 q_pop,
    input  wire logic            pop,
    output logic                 empty,
    output logic                 found,
    output logic [7:0]           target_index
);

    typedef logic [4:0] step_t;

    // product issued in each step; it is registered in p_reg, then accumulated
    localparam step_t STEP_C2    = 5'd0;
    localparam step_t STEP_FX    = 5'd1;
    localparam step_t STEP_FY    = 5'd2;
    localparam step_t STEP_DX    = 5'd3;
    localparam step_t STEP_DY    = 5'd4;
    localparam step_t STEP_C2F2  = 5'd5;
    localparam step_t STEP_DOTX  = 5'd6;
    localparam step_t STEP_DOTY  = 5'd7;
    localparam step_t STEP_RR    = 5'd8;
    localparam step_t STEP_R_LL  = 5'd9;
    localparam step_t STEP_R_LH  = 5'd10;
    localparam step_t STEP_R_HL  = 5'd11;
    localparam step_t STEP_R_HH  = 5'd12;
    localparam step_t STEP_L_LL  = 5'd13;
    localparam step_t STEP_L_LH  = 5'd14;
    localparam step_t STEP_L_HH  = 5'd15;
    localparam step_t STEP_FINAL = 5'd16;

    ntis_pkg::back_state_t state_reg;
    ntis_pkg::back_state_t state_next;
    step_t                 step_reg;
    step_t                 acc_step;
    ntis_pkg::cand_t       cur_reg;

    logic [63:0]         p_reg;
    logic [30:0]         c2_reg;
    logic [31:0]         f2_reg;
    logic [49:0]         d2_reg;
    logic [61:0]         c2f2_reg;
    logic signed [41:0]  dot_reg;
    logic [45:0]         rr_reg;
    logic [40:0]         adot_reg;
    logic [111:0]        rhs_reg;
    logic [81:0]         lhs_reg;

    logic [47:0] best_d2_reg;
    logic [7:0]  best_idx_reg;
    logic        have_best_reg;
    logic        out_valid_reg;
    logic        found_reg;
    logic [7:0]  target_index_reg;

    logic               load;
    logic               finish;
    logic               slot_free;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [15:0]        cos_bits;
    logic [15:0]        cmag;
    logic signed [41:0] p_ext;
    logic               neg_x;
    logic               neg_y;
    logic [111:0]       l2;
    logic               cpos;
    logic               cneg;
    logic               cone_ok;
    logic               qual;
    logic               upd;
    logic               new_have;
    logic [7:0]         new_idx;

    assign cos_bits  = cfg.cos_half_arc;
    assign cmag      = cos_bits[15] ? (~cos_bits + 16'd1) : cos_bits;
    assign p_ext     = $signed({1'b0, p_reg[40:0]});
    assign neg_x     = cur_reg.sdx ^ cur_reg.sfx;
    assign neg_y     = cur_reg.sdy ^ cur_reg.sfy;
    assign acc_step  = step_reg - 5'd1;
    assign slot_free = !out_valid_reg || pop;

    // operand select for the shared 32x32 multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            STEP_C2:
            begin
                mul_a = 32'(cmag);
                mul_b = 32'(cmag);
            end
            STEP_FX:
            begin
                mul_a = 32'(cur_reg.afx);
                mul_b = 32'(cur_reg.afx);
            end
            STEP_FY:
            begin
                mul_a = 32'(cur_reg.afy);
                mul_b = 32'(cur_reg.afy);
            end
            STEP_DX:
            begin
                mul_a = 32'(cur_reg.adx);
                mul_b = 32'(cur_reg.adx);
            end
            STEP_DY:
            begin
                mul_a = 32'(cur_reg.ady);
                mul_b = 32'(cur_reg.ady);
            end
            STEP_C2F2:
            begin
                mul_a = 32'(c2_reg);
                mul_b = f2_reg;
            end
            STEP_DOTX:
            begin
                mul_a = 32'(cur_reg.adx);
                mul_b = 32'(cur_reg.afx);
            end
            STEP_DOTY:
            begin
                mul_a = 32'(cur_reg.ady);
                mul_b = 32'(cur_reg.afy);
            end
            STEP_RR:
            begin
                mul_a = 32'(cfg.reach);
                mul_b = 32'(cfg.reach);
            end
            STEP_R_LL:
            begin
                mul_a = c2f2_reg[31:0];
                mul_b = d2_reg[31:0];
            end
            STEP_R_LH:
            begin
                mul_a = c2f2_reg[31:0];
                mul_b = 32'(d2_reg[49:32]);
            end
            STEP_R_HL:
            begin
                mul_a = 32'(c2f2_reg[61:32]);
                mul_b = d2_reg[31:0];
            end
            STEP_R_HH:
            begin
                mul_a = 32'(c2f2_reg[61:32]);
                mul_b = 32'(d2_reg[49:32]);
            end
            STEP_L_LL:
            begin
                mul_a = adot_reg[31:0];
                mul_b = adot_reg[31:0];
            end
            STEP_L_LH:
            begin
                mul_a = adot_reg[31:0];
                mul_b = 32'(adot_reg[40:32]);
            end
            STEP_L_HH:
            begin
                mul_a = 32'(adot_reg[40:32]);
                mul_b = 32'(adot_reg[40:32]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // decide: (32768*dot)^2 against cos^2 * f2 * d2, with signs
    assign l2   = {lhs_reg, 30'd0};
    assign cpos = !cos_bits[15] && (cos_bits != 16'd0);
    assign cneg = cos_bits[15];

    always_comb
    begin
        if (dot_reg[41])
            cone_ok = cneg && !(l2 > rhs_reg);
        else
            cone_ok = !cpos || !(l2 < rhs_reg);
    end

    assign qual = cur_reg.alive && (d2_reg != 50'd0) && (d2_reg <= {4'd0, rr_reg})
                  && (f2_reg != 32'd0) && cone_ok;
    assign upd      = qual && (d2_reg < {2'd0, best_d2_reg});
    assign new_have = have_best_reg || upd;
    assign new_idx  = upd ? cur_reg.idx : best_idx_reg;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load       = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            ntis_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    load       = 1'b1;
                    state_next = q_head.alive ? ntis_pkg::BK_RUN : ntis_pkg::BK_DONE;
                end
            end
            ntis_pkg::BK_RUN:
            begin
                if (step_reg == STEP_FINAL)
                    state_next = ntis_pkg::BK_DONE;
            end
            ntis_pkg::BK_DONE:
            begin
                // hold while a finished query's result still waits
                if (!cur_reg.last || slot_free)
                begin
                    finish     = 1'b1;
                    state_next = ntis_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ntis_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ntis_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= '0;
            best_d2_reg      <= '1;
            best_idx_reg     <= '0;
            have_best_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            found_reg        <= 1'b0;
            target_index_reg <= '0;
        end
        else
        begin
            if (load)
                step_reg <= '0;
            else if (state_reg == ntis_pkg::BK_RUN)
                step_reg <= step_reg + 5'd1;

            if (finish && cur_reg.last)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;

            if (finish)
            begin
                if (cur_reg.last)
                begin
                    found_reg        <= new_have;
                    target_index_reg <= new_have ? new_idx : 8'd0;
                    best_d2_reg      <= '1;
                    best_idx_reg     <= '0;
                    have_best_reg    <= 1'b0;
                end
                else if (upd)
                begin
                    best_d2_reg   <= d2_reg[47:0];
                    best_idx_reg  <= cur_reg.idx;
                    have_best_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: multiplier register and accumulation of the prior product
    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= q_head;

        p_reg <= mul_a * mul_b;

        if (state_reg == ntis_pkg::BK_RUN)
        begin
            if (step_reg == STEP_R_LL)
                adot_reg <= dot_reg[41] ? 41'(-dot_reg) : 41'(dot_reg);

            case (acc_step)
                STEP_C2:   c2_reg   <= p_reg[30:0];
                STEP_FX:   f2_reg   <= p_reg[31:0];
                STEP_FY:   f2_reg   <= f2_reg + p_reg[31:0];
                STEP_DX:   d2_reg   <= 50'(p_reg);
                STEP_DY:   d2_reg   <= d2_reg + 50'(p_reg);
                STEP_C2F2: c2f2_reg <= p_reg[61:0];
                STEP_DOTX: dot_reg  <= neg_x ? (42'sd0 - p_ext) : p_ext;
                STEP_DOTY: dot_reg  <= neg_y ? (dot_reg - p_ext) : (dot_reg + p_ext);
                STEP_RR:   rr_reg   <= p_reg[45:0];
                STEP_R_LL: rhs_reg  <= 112'(p_reg);
                STEP_R_LH: rhs_reg  <= rhs_reg + (112'(p_reg) << 32);
                STEP_R_HL: rhs_reg  <= rhs_reg + (112'(p_reg) << 32);
                STEP_R_HH: rhs_reg  <= rhs_reg + (112'(p_reg) << 64);
                STEP_L_LL: lhs_reg  <= 82'(p_reg);
                STEP_L_LH: lhs_reg  <= lhs_reg + (82'(p_reg) << 33);
                STEP_L_HH: lhs_reg  <= lhs_reg + (82'(p_reg) << 64);
                default:   ;
            endcase
        end
    end

    assign empty        = !out_valid_reg;
    assign found        = found_reg;
    assign target_index = target_index_reg;

endmodule

`default_nettype wire

FILE: sv/nearest_target_in_sector_unit.sv
// ----------------------------------------------------------------------------
// nearest_target_in_sector_unit
// Nearest live candidate inside a view cone, one result per candidate list.
// ----------------------------------------------------------------------------
// Candidates are pushed one per request; the request flagged last_candidate
// closes the list and one result (found, target_index) appears in the result
// slot. A candidate with positive health and an index below MAX_CANDIDATES
// runs the back end's tests, where one shared 32x32 multiplier steps
// through the sixteen partial products of the range and cone tests; any other
// candidate skips them. Up to four classified candidates wait in a queue
// ahead of the back end, so pushes continue while a result waits to be
// popped. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_target_in_sector_unit #(
    parameter int MAX_CANDIDATES = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [23:0] player_x,
    input  wire logic signed [23:0] player_y,
    input  wire logic signed [15:0] forward_x,
    input  wire logic signed [15:0] forward_y,
    input  wire logic signed [23:0] cand_x,
    input  wire logic signed [23:0] cand_y,
    input  wire logic signed [10:0] remaining_health,
    input  wire logic               last_candidate,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    found,
    output logic [7:0]              target_index,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [22:0]        cfg_data
);

    ntis_pkg::cfg_t  cfg_reg;
    ntis_pkg::cand_t q_wr_data;
    ntis_pkg::cand_t q_rd_data;
    logic            q_wr;
    logic            q_rd;
    logic            q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reach        <= ntis_pkg::REACH_RESET;
            cfg_reg.cos_half_arc <= ntis_pkg::COS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ntis_pkg::CFG_REACH: cfg_reg.reach        <= cfg_data;
                ntis_pkg::CFG_COS:   cfg_reg.cos_half_arc <= cfg_data[15:0];
                default:             ;
            endcase
        end
    end

    ntis_front #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .q_full           (full),
        .player_x         (player_x),
        .player_y         (player_y),
        .forward_x        (forward_x),
        .forward_y        (forward_y),
        .cand_x           (cand_x),
        .cand_y           (cand_y),
        .remaining_health (remaining_health),
        .last_candidate   (last_candidate),
        .q_push           (q_wr),
        .q_entry          (q_wr_data)
    );

    ntis_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .full    (full),
        .empty   (q_empty)
    );

    ntis_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_head       (q_rd_data),
        .q_pop        (q_rd),
        .pop          (pop),
        .empty        (empty),
        .found        (found),
        .target_index (target_index)
    );

endmodule

`default_nettype wire

FILE: sv/ntis_checker.sv
// ----------------------------------------------------------------------------
// ntis_checker
// Port-level checks of the nearest target in sector unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ntis_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       last_candidate,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic       found,
    input wire logic [7:0] target_index
);

    logic [3:0] pend_reg;
    logic       last_in;
    logic       res_out;

    assign last_in = push && !full && last_candidate;
    assign res_out = pop && !empty;

    // lists closed whose result has not been popped yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (last_in && !res_out)
            pend_reg <= pend_reg + 4'd1;
        else if (res_out && !last_in)
            pend_reg <= pend_reg - 4'd1;
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(found) && $stable(target_index)))
        else $error("result changed or vanished before pop");

    a_index_zero_when_missed: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !found) |-> (target_index == 8'd0))
        else $error("target_index nonzero on a not-found result");

    a_result_has_list: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pend_reg != 4'd0))
        else $error("result shown with no closed list outstanding");

    a_drain_to_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out && (pend_reg == 4'd1) && !last_in) |=> empty)
        else $error("extra result after the only outstanding one was popped");

endmodule

bind nearest_target_in_sector_unit ntis_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .last_candidate (last_candidate),
    .empty          (empty),
    .pop            (pop),
    .found          (found),
    .target_index   (target_index)
);

`default_nettype wire
